// ===== rtl/qstpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// qstpwm_pkg
// Shared types and constants for the quintic servo trajectory PWM unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qstpwm_pkg;

   localparam int unsigned WORD_W  = 54;
   localparam int unsigned ANGLE_W = 16;
   localparam int unsigned TIME_W  = 26;
   localparam int unsigned PULSE_W = 13;
   localparam int unsigned PULSE_FIELD_MAX = 8191;

   localparam logic [1:0] REG_PITCH = 2'd0;
   localparam logic [1:0] REG_ROLL  = 2'd1;
   localparam logic [1:0] REG_YAW   = 2'd2;

   localparam logic [WORD_W-1:0] PITCH_RESET = 54'd1501137824907385;
   localparam logic [WORD_W-1:0] ROLL_RESET  = 54'd1501108320646325;
   localparam logic [WORD_W-1:0] YAW_RESET   = 54'd1501351009968369;

   typedef struct packed {
      logic [1:0]        idx;
      logic              bad;
      logic              last;
      logic [WORD_W-1:0] word;
      logic [TIME_W-1:0] wait_us;
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/quintic_servo_trajectory_pwm_unit.sv =====
// ----------------------------------------------------------------------------
// quintic_servo_trajectory_pwm_unit
// Quintic servo move to a train of PWM pulse counts, one per step.
// ----------------------------------------------------------------------------
// Usage: a request word names a servo, start and end angles (Q9.7 degrees)
// and a move time. The block answers with STEPS+1 response words, one per
// cycle while rsp_stall is low, each with the channel, the PWM high-time
// count and the per-step wait; final_step marks the last one. An out-of-range
// servo gives a single word with bad_index and final_step set.
// The csr_ port writes the three servo setup words; the user must write them
// only while the unit is idle, which the block itself does not enforce.
// The step sequencer takes the next request in the cycle the last step of the
// current one issues, while earlier steps are still in the pipeline.
// Reset restores the factory setup words and empties the sequencer and the
// nine-stage pipeline. While rsp_stall is high and a word is offered,
// every stage holds.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_servo_trajectory_pwm_unit #(
   parameter int STEPS       = 50,
   parameter int PWM_BITS    = 13,
   parameter int SERVO_COUNT = 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_servo_index,
   input  wire logic signed [qstpwm_pkg::ANGLE_W-1:0] req_start_angle,
   input  wire logic signed [qstpwm_pkg::ANGLE_W-1:0] req_end_angle,
   input  wire logic [qstpwm_pkg::TIME_W-1:0]       req_move_time_us,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_channel,
   output logic [qstpwm_pkg::PULSE_W-1:0]           rsp_pulse_count,
   output logic [qstpwm_pkg::TIME_W-1:0]            rsp_wait_us,
   output logic                                     rsp_bad_index,
   output logic                                     rsp_final_step,
   input  wire logic                                csr_write_enable,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [qstpwm_pkg::WORD_W-1:0]       csr_write_data
);
   import qstpwm_pkg::*;

   localparam int IW = $clog2(STEPS + 1);
   localparam int FK = 18;
   localparam longint DEN = longint'(STEPS) * STEPS * STEPS * STEPS * STEPS;
   localparam longint DEN_HALF = DEN / 2;
   localparam logic [32:0] RW_MUL = 33'((64'd4294967296 + STEPS - 1) / STEPS);
   localparam logic [28:0] RP_MUL = 29'((64'd68719476736 + 224) / 225);
   localparam int ZW = PWM_BITS + 7;
   localparam longint PMAX = (longint'(1) << PWM_BITS) - 1;
   localparam longint LIM = (PMAX > PULSE_FIELD_MAX) ? PULSE_FIELD_MAX : PMAX;

   typedef logic [30:0] num_tab_type [STEPS+1];
   typedef logic [FK:0] frac_tab_type [STEPS+1];

   function automatic longint num_of(input longint i);
      longint n;
      n = STEPS;
      return i * i * i * (10 * n * n - 15 * i * n + 6 * i * i);
   endfunction

   function automatic num_tab_type make_num();
      num_tab_type t;
      for (int i = 0; i <= STEPS; i++) begin
         t[i] = 31'(num_of(longint'(i)));
      end
      return t;
   endfunction

   function automatic frac_tab_type make_frac();
      frac_tab_type t;
      for (int i = 0; i <= STEPS; i++) begin
         t[i] = (FK+1)'((num_of(longint'(i)) <<< FK) / DEN);
      end
      return t;
   endfunction

   localparam num_tab_type  NUM_TAB  = make_num();
   localparam frac_tab_type FRAC_TAB = make_frac();

   // setup registers
   logic [WORD_W-1:0] setup_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff[REG_PITCH] <= PITCH_RESET;
         setup_ff[REG_ROLL]  <= ROLL_RESET;
         setup_ff[REG_YAW]   <= YAW_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PITCH: setup_ff[REG_PITCH] <= csr_write_data;
            REG_ROLL:  setup_ff[REG_ROLL]  <= csr_write_data;
            REG_YAW:   setup_ff[REG_YAW]   <= csr_write_data;
            default:   ;
         endcase
      end
   end

   // step sequencer
   logic                    busy_ff;
   logic [IW-1:0]           step_ff;
   logic signed [15:0]      a0_ff;
   logic signed [16:0]      d_ff;
   logic [1:0]              idx_ff;
   logic                    bad_ff;
   logic [TIME_W-1:0]       dur_ff;
   logic                    adv, issue, seq_last, accept;
   logic [WORD_W-1:0]       word_sel;

   assign adv      = !(rsp_valid && rsp_stall);
   assign issue    = busy_ff && adv;
   assign seq_last = bad_ff || (step_ff == IW'(STEPS));
   assign req_stall = busy_ff && !(issue && seq_last);
   assign accept   = req_valid && !req_stall;

   always_comb begin
      unique case (idx_ff)
         REG_ROLL: word_sel = setup_ff[REG_ROLL];
         REG_YAW:  word_sel = setup_ff[REG_YAW];
         default:  word_sel = setup_ff[REG_PITCH];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (issue && seq_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= '0;
         a0_ff   <= req_start_angle;
         d_ff    <= 17'(req_end_angle) - 17'(req_start_angle);
         idx_ff  <= req_servo_index;
         bad_ff  <= (32'(req_servo_index) >= SERVO_COUNT) || (req_servo_index == 2'd3);
         dur_ff  <= req_move_time_us;
      end else if (issue) begin
         step_ff <= step_ff + IW'(1);
      end
   end

   // pipeline valid bits
   logic [9:1] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[8:1], issue};
      end
   end

   // stage payloads
   side_type           s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff;
   logic signed [15:0] a1_ff, a2_ff, a3_ff;
   logic signed [48:0] p1_ff;
   logic signed [36:0] e1_ff;
   logic [58:0]        wp1_ff;
   logic signed [18:0] est2_ff, est3_ff;
   logic signed [48:0] y2_ff, y3_ff;
   logic signed [51:0] m3_ff;
   logic signed [16:0] th4_ff;
   logic signed [19:0] t5_ff;
   logic signed [36:0] prod6_ff;
   logic [15:0]        th7_ff;
   logic [ZW+28:0]     prod8_ff;

   logic signed [51:0] r4_in;
   logic signed [18:0] q4_in;
   logic signed [19:0] th4_in;
   logic signed [17:0] rev5_in;
   logic signed [16:0] off5_in, zero5_in, zero7_in;
   logic signed [22:0] sh7_in;
   logic signed [23:0] th7_in, mx7_in, mn7_in, cl7_in;
   logic [16:0]        x8_in;
   logic [ZW-1:0]      z8_in, cnt9_in;

   always_comb begin
      r4_in = 52'(y3_ff) - m3_ff;
      if (r4_in < 0) begin
         q4_in = est3_ff - 19'sd1;
      end else if (r4_in >= 52'(DEN)) begin
         q4_in = est3_ff + 19'sd1;
      end else begin
         q4_in = est3_ff;
      end
      th4_in = 20'(a3_ff) + 20'(q4_in);

      rev5_in  = s4_ff.word[0] ? (18'sd23040 - 18'(th4_ff)) : 18'(th4_ff);
      off5_in  = $signed({s4_ff.word[37:28], 7'b0});
      zero5_in = $signed({1'b0, s4_ff.word[9:1], 7'b0});

      zero7_in = $signed({1'b0, s6_ff.word[9:1], 7'b0});
      sh7_in   = 23'((prod6_ff + 37'sd8192) >>> 14);
      th7_in   = 24'(sh7_in) + 24'(zero7_in);
      mx7_in   = $signed({8'b0, s6_ff.word[27:19], 7'b0});
      mn7_in   = $signed({8'b0, s6_ff.word[18:10], 7'b0});
      if (th7_in > mx7_in) begin
         cl7_in = mx7_in;
      end else if (th7_in < mn7_in) begin
         cl7_in = mn7_in;
      end else begin
         cl7_in = th7_in;
      end
      if (cl7_in < 0) begin
         cl7_in = '0;
      end

      x8_in   = 17'(th7_ff) + 17'd5760;
      z8_in   = ZW'({x8_in, {PWM_BITS{1'b0}}} >> 10);
      cnt9_in = ZW'(prod8_ff >> 36);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: table lookup and products
         s1_ff.idx     <= idx_ff;
         s1_ff.bad     <= bad_ff;
         s1_ff.last    <= seq_last;
         s1_ff.word    <= word_sel;
         s1_ff.wait_us <= '0;
         a1_ff  <= a0_ff;
         p1_ff  <= d_ff * $signed({1'b0, NUM_TAB[step_ff]});
         e1_ff  <= d_ff * $signed({1'b0, FRAC_TAB[step_ff]});
         wp1_ff <= 59'(dur_ff) * 59'(RW_MUL);
         // stage 2: quotient estimate
         s2_ff   <= '{idx: s1_ff.idx, bad: s1_ff.bad, last: s1_ff.last,
                      word: s1_ff.word, wait_us: TIME_W'(wp1_ff >> 32)};
         a2_ff   <= a1_ff;
         est2_ff <= 19'((e1_ff + 37'sd131072) >>> FK);
         y2_ff   <= p1_ff + 49'(DEN_HALF);
         // stage 3: back-multiply
         s3_ff   <= s2_ff;
         a3_ff   <= a2_ff;
         est3_ff <= est2_ff;
         y3_ff   <= y2_ff;
         m3_ff   <= 52'(est2_ff) * 52'(DEN);
         // stage 4: correct quotient
         s4_ff  <= s3_ff;
         th4_ff <= 17'(th4_in);
         // stage 5: reverse and offset
         s5_ff <= s4_ff;
         t5_ff <= 20'(rev5_in) - 20'(off5_in) - 20'(zero5_in);
         // stage 6: scale
         s6_ff    <= s5_ff;
         prod6_ff <= 37'(t5_ff) * 37'($signed({1'b0, s5_ff.word[53:38]}));
         // stage 7: round and clamp
         s7_ff  <= s6_ff;
         th7_ff <= 16'(cl7_in);
         // stage 8: pulse reciprocal
         s8_ff    <= s7_ff;
         prod8_ff <= (ZW+29)'(z8_in) * (ZW+29)'(RP_MUL);
         // stage 9: saturate and drive
         rsp_channel     <= s8_ff.bad ? 2'd0 : s8_ff.idx;
         rsp_wait_us     <= s8_ff.bad ? '0 : s8_ff.wait_us;
         rsp_bad_index   <= s8_ff.bad;
         rsp_final_step  <= s8_ff.last;
         if (s8_ff.bad) begin
            rsp_pulse_count <= '0;
         end else if (cnt9_in > ZW'(LIM)) begin
            rsp_pulse_count <= PULSE_W'(LIM);
         end else begin
            rsp_pulse_count <= PULSE_W'(cnt9_in);
         end
      end
   end

   assign rsp_valid = v_ff[9];

   a_bad_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_final_step && rsp_pulse_count == '0)
      else $error("bad index word not final");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy_ff && step_ff == '0)
      else $error("sequencer not loaded");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= IW'(STEPS))
      else $error("step out of range");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !adv && busy_ff |=> $stable(v_ff) && $stable(step_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// quintic servo trajectory PWM unit testbench
// Drives servo move requests through the valid/stall channel, predicts every
// response word from the quintic trajectory and the servo setup words, and
// compares each word in order. Setup words are rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import qstpwm_pkg::*;

   localparam int STEPS = 50;
   localparam int PWM_BITS = 13;
   localparam int SERVO_COUNT = 3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DIRECTED_ROWS = 14;

   typedef struct packed {
      logic [1:0]         channel;
      logic [PULSE_W-1:0] pulse;
      logic [TIME_W-1:0]  wait_us;
      logic               bad;
      logic               last;
   } pulse_word_type;

   typedef struct {
      logic [1:0]                servo;
      logic signed [ANGLE_W-1:0] a0;
      logic signed [ANGLE_W-1:0] a1;
      logic [TIME_W-1:0]         dur;
      bit                        typed;
      logic [PULSE_W-1:0]        first_pulse;
   } move_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_servo_index = '0;
   logic signed [ANGLE_W-1:0] req_start_angle = '0;
   logic signed [ANGLE_W-1:0] req_end_angle = '0;
   logic [TIME_W-1:0] req_move_time_us = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_channel;
   logic [PULSE_W-1:0] rsp_pulse_count;
   logic [TIME_W-1:0] rsp_wait_us;
   logic rsp_bad_index;
   logic rsp_final_step;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_write_data = '0;

   logic [WORD_W-1:0] setup_word [3];
   pulse_word_type pending_pulses[$];
   move_row_type directed [DIRECTED_ROWS];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;

   always #5 clock = ~clock;

   quintic_servo_trajectory_pwm_unit u_dut (.*);

   function automatic longint floor_div(longint x, longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && x < 0) q--;
      return q;
   endfunction

   function automatic logic [PULSE_W-1:0] angle_to_pulse(logic [WORD_W-1:0] w,
                                                         longint theta);
      longint zero, mn, mx, off, scale, t;
      longint unsigned cnt;
      zero = longint'(w[9:1]) * 128;
      mn = longint'(w[18:10]) * 128;
      mx = longint'(w[27:19]) * 128;
      off = longint'($signed(w[37:28])) * 128;
      scale = longint'(w[53:38]);
      if (w[0]) theta = 180 * 128 - theta;
      t = theta - off - zero;
      theta = floor_div(t * scale + 8192, 16384) + zero;
      if (theta > mx) theta = mx;
      else if (theta < mn) theta = mn;
      if (theta < 0) theta = 0;
      cnt = ((theta + 5760) << PWM_BITS) / 230400;
      if (cnt > PULSE_FIELD_MAX) cnt = PULSE_FIELD_MAX;
      return cnt[PULSE_W-1:0];
   endfunction

   task automatic predict_move(logic [1:0] servo, logic signed [ANGLE_W-1:0] a0,
                               logic signed [ANGLE_W-1:0] a1, logic [TIME_W-1:0] dur);
      longint n, den, d, num, theta;
      pulse_word_type w;
      n = STEPS;
      den = n * n * n * n * n;
      d = longint'(a1) - longint'(a0);
      if (servo >= SERVO_COUNT) begin
         w = '{channel: 2'd0, pulse: '0, wait_us: '0, bad: 1'b1, last: 1'b1};
         pending_pulses.push_back(w);
         return;
      end
      for (longint i = 0; i <= n; i++) begin
         num = i * i * i * (10 * n * n - 15 * i * n + 6 * i * i);
         theta = longint'(a0) + floor_div(d * num + den / 2, den);
         w.channel = servo;
         w.pulse = angle_to_pulse(setup_word[servo], theta);
         w.wait_us = TIME_W'(dur / STEPS);
         w.bad = 1'b0;
         w.last = (i == n);
         pending_pulses.push_back(w);
      end
   endtask

   task automatic write_setup(logic [1:0] idx, logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx < 3) setup_word[idx] = value;
   endtask

   task automatic drain_moves();
      req_valid <= 1'b0;
      while (pending_pulses.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_move(logic [1:0] servo, logic signed [ANGLE_W-1:0] a0,
                            logic signed [ANGLE_W-1:0] a1, logic [TIME_W-1:0] dur);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_servo_index <= servo;
      req_start_angle <= a0;
      req_end_angle <= a1;
      req_move_time_us <= dur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_move(servo, a0, a1, dur);
      @(negedge clock);
   endtask

   task automatic random_setup();
      logic [WORD_W-1:0] v;
      v = {$urandom(), $urandom()};
      if ($urandom_range(0, 3) != 0) begin
         v[53:38] = 16'd16384 + 16'($urandom_range(0, 8000)) - 16'd4000;
         v[27:19] = 9'($urandom_range(90, 300));
         v[18:10] = 9'($urandom_range(0, 90));
      end
      write_setup(2'($urandom_range(0, 3)), v);
   endtask

   // response checker
   always @(posedge clock) begin
      pulse_word_type got, exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_channel, rsp_pulse_count, rsp_wait_us, rsp_bad_index,
                 rsp_final_step};
         if (pending_pulses.size() == 0) begin
            $display("%0t unexpected word: actual %h", $time, got);
            errors++;
         end else begin
            exp_w = pending_pulses.pop_front();
            if (got !== exp_w) begin
               $display("%0t mismatch: expected ch=%0d pc=%0d w=%0d b=%b f=%b",
                        $time, exp_w.channel, exp_w.pulse, exp_w.wait_us,
                        exp_w.bad, exp_w.last);
               $display("%0t           actual ch=%0d pc=%0d w=%0d b=%b f=%b",
                        $time, got.channel, got.pulse, got.wait_us, got.bad, got.last);
               errors++;
            end
         end
      end
   end

   // receiver stall
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_stall <= 1'b1;
         else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
            if (!hold_rsp) begin
               @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end else rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_rsp)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      directed[0]  = '{2'd0, 16'sd0, 16'sd11520, 26'd100000, 1'b1, 13'd493};
      directed[1]  = '{2'd1, 16'sd11520, 16'sd0, 26'd0, 1'b0, '0};
      directed[2]  = '{2'd2, 16'sd23040, 16'sd0, 26'd67108863, 1'b0, '0};
      directed[3]  = '{2'd3, 16'sd100, 16'sd200, 26'd5000, 1'b0, '0};
      directed[4]  = '{2'd0, -16'sd32768, 16'sd32767, 26'd49, 1'b0, '0};
      directed[5]  = '{2'd1, 16'sd32767, -16'sd32768, 26'd50, 1'b0, '0};
      directed[6]  = '{2'd2, 16'sd0, 16'sd0, 26'd1, 1'b0, '0};
      directed[7]  = '{2'd3, -16'sd32768, 16'sd32767, 26'd67108863, 1'b0, '0};
      directed[8]  = '{2'd0, 16'sd5760, 16'sd17280, 26'd2000000, 1'b0, '0};
      directed[9]  = '{2'd1, -16'sd1, 16'sd1, 26'd33554432, 1'b0, '0};
      directed[10] = '{2'd2, 16'sd32767, 16'sd32767, 26'd12345, 1'b0, '0};
      directed[11] = '{2'd0, -16'sd32768, -16'sd32768, 26'd99, 1'b0, '0};
      directed[12] = '{2'd1, 16'sd21845, -16'sd10923, 26'd43690, 1'b0, '0};
      directed[13] = '{2'd2, -16'sd21846, 16'sd10922, 26'd22369621, 1'b0, '0};
      setup_word[0] = PITCH_RESET;
      setup_word[1] = ROLL_RESET;
      setup_word[2] = YAW_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         send_move(directed[k].servo, directed[k].a0, directed[k].a1, directed[k].dur);
         if (directed[k].typed && pending_pulses.size() >= STEPS + 1)
            pending_pulses[pending_pulses.size() - STEPS - 1].pulse =
               directed[k].first_pulse;
      end
      drain_moves();

      // extreme setups: all ones, all zeros, min above max, reversal
      write_setup(REG_PITCH, '1);
      write_setup(REG_ROLL, '0);
      write_setup(REG_YAW, {16'd16384, 10'h200, 9'd10, 9'd200, 9'd90, 1'b1});
      write_setup(2'd3, '1);
      foreach (directed[k])
         send_move(directed[k].servo, directed[k].a0, directed[k].a1, directed[k].dur);
      drain_moves();

      // fill the pipeline against a long receiver hold
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         repeat (8) send_move(2'($urandom_range(0, 3)), 16'($urandom()),
                              16'($urandom()), 26'($urandom()));
      join
      drain_moves();

      for (int ph = 0; ph < 6; ph++) begin
         repeat (2) random_setup();
         if (ph == 5) quiet = 1'b1;
         for (int j = 0; j < 62; j++) begin
            logic signed [ANGLE_W-1:0] a, b;
            a = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                             : 16'(int'($urandom_range(0, 23040)));
            b = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                             : 16'(int'($urandom_range(0, 23040)));
            send_move(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                      a, b, 26'($urandom()));
            if (j == 30) begin
               req_valid <= 1'b0;
               while (pending_pulses.size() != 0) @(negedge clock);
               @(negedge clock);
            end
         end
         drain_moves();
      end

      if (errors == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule
